/* rtl/core/wemu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wemu_pkg
// shared constants and types of the four-wheel multi-turn encoder unwrap
// ----------------------------------------------------------------------------
package wemu_pkg;

    localparam int WHEELS        = 4;
    localparam int RAW_IN_W      = 16;   // width of each raw angle field
    localparam int CFG_W         = 16;   // widest configuration register
    localparam int CFG_IDX_W     = 2;
    localparam int POS_W         = 31;   // signed position width
    localparam int THR_W         = 16;
    localparam int PERIOD_W      = 16;
    localparam int HDR_W         = 8;

    localparam int TURN_BITS_DEF = 16;
    localparam int RAW_BITS_DEF  = 16;

    localparam logic [HDR_W-1:0] HDR_START = 8'hDF;
    localparam logic [HDR_W-1:0] HDR_CMD   = 8'h41;

    localparam logic [PERIOD_W-1:0] WRAP_PERIOD_RST    = 16'd27204;
    localparam logic [THR_W-1:0]    JUMP_THRESHOLD_RST = 16'd10000;
    localparam logic [WHEELS-1:0]   INVERT_MASK_RST    = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRAP_PERIOD    = 2'd0,
        REG_JUMP_THRESHOLD = 2'd1,
        REG_INVERT_MASK    = 2'd2
    } cfg_reg_t;

    // control from the top level to one wheel tracker
    typedef struct packed {
        logic load;     // item moves into the tracking stage
        logic hdr_ok;   // header matched, take the new raw value
    } track_ctrl_t;

endpackage

/* rtl/core/wemu_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wemu_track
// per-wheel wrap detection and saturating turn counter
// ----------------------------------------------------------------------------
module wemu_track #(
    parameter int TURN_BITS = wemu_pkg::TURN_BITS_DEF,
    parameter int RAW_BITS  = wemu_pkg::RAW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wemu_pkg::track_ctrl_t       ctrl,
    input  logic [RAW_BITS-1:0]         raw,
    input  logic [wemu_pkg::THR_W-1:0]  threshold,
    output logic [RAW_BITS-1:0]         cur,
    output logic signed [TURN_BITS-1:0] turn
);
    import wemu_pkg::*;

    localparam int DIFF_W = ((RAW_BITS > THR_W) ? RAW_BITS : THR_W) + 2;
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    logic [RAW_BITS-1:0]         last_raw_reg;
    logic [RAW_BITS-1:0]         last_raw_next;
    logic signed [TURN_BITS-1:0] turn_reg;
    logic signed [TURN_BITS-1:0] turn_next;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [DIFF_W-1:0]    thr_s;
    logic                        jump_up;
    logic                        jump_down;

    assign last_raw_next = ctrl.hdr_ok ? raw : last_raw_reg;
    assign diff  = $signed(DIFF_W'(last_raw_next)) - $signed(DIFF_W'(last_raw_reg));
    assign thr_s = $signed(DIFF_W'(threshold));

    assign jump_up   = diff > thr_s;
    assign jump_down = diff < -thr_s;

    always_comb
    begin
        turn_next = turn_reg;
        if (jump_up)
        begin
            if (turn_reg != TURN_MIN)
                turn_next = turn_reg - TURN_BITS'(1);
        end
        else if (jump_down)
        begin
            if (turn_reg != TURN_MAX)
                turn_next = turn_reg + TURN_BITS'(1);
        end
    end

    // the state doubles as the stage register holding the current item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= '0;
            turn_reg     <= '0;
        end
        else if (ctrl.load)
        begin
            last_raw_reg <= last_raw_next;
            turn_reg     <= turn_next;
        end
    end

    assign cur  = last_raw_reg;
    assign turn = turn_reg;

endmodule

/* rtl/core/wemu_position.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wemu_position
// raw + period * turns, optional negation, clamp to the position range
// ----------------------------------------------------------------------------
module wemu_position #(
    parameter int TURN_BITS = wemu_pkg::TURN_BITS_DEF,
    parameter int RAW_BITS  = wemu_pkg::RAW_BITS_DEF
) (
    input  logic [RAW_BITS-1:0]           cur,
    input  logic signed [TURN_BITS-1:0]   turn,
    input  logic [wemu_pkg::PERIOD_W-1:0] period,
    input  logic                          invert,
    output logic [wemu_pkg::POS_W-1:0]    pos
);
    import wemu_pkg::*;

    localparam int PROD_W = PERIOD_W + 1 + TURN_BITS;
    localparam int CALC_W = (PROD_W + 2 > POS_W + 1) ? PROD_W + 2 : POS_W + 1;
    localparam logic signed [CALC_W-1:0] POS_HI =
        {{(CALC_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [CALC_W-1:0] POS_LO =
        {{(CALC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

    logic signed [PERIOD_W:0]   period_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [CALC_W-1:0]   sum;
    logic signed [CALC_W-1:0]   signed_pos;

    assign period_s = $signed({1'b0, period});
    assign prod     = PROD_W'(period_s) * PROD_W'(turn);
    assign sum      = CALC_W'(prod) + $signed(CALC_W'(cur));
    assign signed_pos = invert ? -sum : sum;

    always_comb
    begin
        if (signed_pos > POS_HI)
            pos = POS_HI[POS_W-1:0];
        else if (signed_pos < POS_LO)
            pos = POS_LO[POS_W-1:0];
        else
            pos = signed_pos[POS_W-1:0];
    end

endmodule

/* rtl/core/wheel_encoder_multiturn_unwrap_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_encoder_multiturn_unwrap_unit
// four-wheel encoder report unwrap into multi-turn signed positions
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  s_*       in         tvalid/tready      one encoder report per transaction
//  m_*       out        tvalid/tready      flag + four positions per transaction
//  cfg_*     in         write enable only  wrap period, jump threshold, invert mask
//
//  one transaction per cycle sustained while m_tready stays high
//  stages: input register, tracking stage (the per-wheel state), output register
//  each stage holds its item only while the next one is full and stalled, so
//  bubbles close up and input is still taken while a result waits at m_*
//  reset clears all valid flags and the wheel state and sets the config registers to defaults
// ----------------------------------------------------------------------------
module wheel_encoder_multiturn_unwrap_unit #(
    parameter int TURN_BITS = wemu_pkg::TURN_BITS_DEF,
    parameter int RAW_BITS  = wemu_pkg::RAW_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // report: start byte, command, raw rf, raw rb, raw lf, raw lb
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [79:0]                    s_tdata,
    // result: pos rf, pos rb, pos lf, pos lb, zero padding
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [127:0]                   m_tdata,
    // frame_accepted
    output logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [wemu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wemu_pkg::CFG_W-1:0]     cfg_data
);
    import wemu_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] wrap_period_reg;
    logic [THR_W-1:0]    jump_threshold_reg;
    logic [WHEELS-1:0]   invert_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_period_reg    <= WRAP_PERIOD_RST;
            jump_threshold_reg <= JUMP_THRESHOLD_RST;
            invert_mask_reg    <= INVERT_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WRAP_PERIOD:    wrap_period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_JUMP_THRESHOLD: jump_threshold_reg <= cfg_data[THR_W-1:0];
                REG_INVERT_MASK:    invert_mask_reg    <= cfg_data[WHEELS-1:0];
                default:            ; // unused index, write dropped
            endcase
        end
    end

    // ready chain: a stage can load when empty or when it is handing off
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    logic in_ready;
    logic mid_ready;
    logic out_ready;
    logic in_load;
    logic mid_load;
    logic out_load;

    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg  || mid_ready;

    assign in_load  = s_tvalid && in_ready;
    assign mid_load = in_valid_reg && mid_ready;
    assign out_load = mid_valid_reg && out_ready;

    logic in_valid_next;
    logic mid_valid_next;
    logic out_valid_next;

    always_comb
    begin
        in_valid_next  = in_ready  ? s_tvalid      : in_valid_reg;
        mid_valid_next = mid_ready ? in_valid_reg  : mid_valid_reg;
        out_valid_next = out_ready ? mid_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register: header check is done on the way in
    logic                in_hdr_ok_reg;
    logic [RAW_IN_W-1:0] in_raw_reg [WHEELS];

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_hdr_ok_reg <= (s_tdata[7:0] == HDR_START) && (s_tdata[15:8] == HDR_CMD);
            for (int w = 0; w < WHEELS; w++)
                in_raw_reg[w] <= s_tdata[16 + w*RAW_IN_W +: RAW_IN_W];
        end
    end

    // tracking stage: the wheel state updates exactly once per item
    logic                        mid_accepted_reg;
    track_ctrl_t                 track_ctrl;
    logic [RAW_BITS-1:0]         lane_cur  [WHEELS];
    logic signed [TURN_BITS-1:0] lane_turn [WHEELS];
    logic [POS_W-1:0]            lane_pos  [WHEELS];

    assign track_ctrl.load   = mid_load;
    assign track_ctrl.hdr_ok = in_hdr_ok_reg;

    always_ff @(posedge clk)
    begin
        if (mid_load)
            mid_accepted_reg <= in_hdr_ok_reg;
    end

    for (genvar w = 0; w < WHEELS; w++)
    begin : g_lane
        wemu_track #(
            .TURN_BITS (TURN_BITS),
            .RAW_BITS  (RAW_BITS)
        ) u_track (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (track_ctrl),
            .raw       (in_raw_reg[w][RAW_BITS-1:0]),
            .threshold (jump_threshold_reg),
            .cur       (lane_cur[w]),
            .turn      (lane_turn[w])
        );

        // scale, direction and clamp between tracking and output registers
        wemu_position #(
            .TURN_BITS (TURN_BITS),
            .RAW_BITS  (RAW_BITS)
        ) u_position (
            .cur    (lane_cur[w]),
            .turn   (lane_turn[w]),
            .period (wrap_period_reg),
            .invert (invert_mask_reg[w]),
            .pos    (lane_pos[w])
        );
    end

    // output register
    logic             out_accepted_reg;
    logic [POS_W-1:0] out_pos_reg [WHEELS];

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_accepted_reg <= mid_accepted_reg;
            for (int w = 0; w < WHEELS; w++)
                out_pos_reg[w] <= lane_pos[w];
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_accepted_reg;
    assign m_tdata  = {4'b0000, out_pos_reg[3], out_pos_reg[2],
                       out_pos_reg[1], out_pos_reg[0]};

endmodule

/* rtl/core/wemu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wemu_checker
// port-level checks of the encoder unwrap unit, bound to the top level
// ----------------------------------------------------------------------------
module wemu_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [127:0]                   m_tdata,
    input logic                           m_tuser,
    input logic                           cfg_we,
    input logic [wemu_pkg::CFG_IDX_W-1:0] cfg_index
);
    import wemu_pkg::*;

    logic [2:0]   pending_reg;
    logic [2:0]   pending_next;
    logic [127:0] last_data_reg;
    logic         cfg_seen_reg;
    logic         in_xfer;
    logic         out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
            pending_next = pending_reg + 3'd1;
        else if (out_xfer && !in_xfer)
            pending_next = pending_reg - 3'd1;
    end

    // last delivered result; a config write may change the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            last_data_reg <= '0;
            cfg_seen_reg  <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_xfer)
            begin
                last_data_reg <= m_tdata;
                cfg_seen_reg  <= 1'b0;
            end
            if (cfg_we && (cfg_index == CFG_IDX_W'(REG_WRAP_PERIOD)
                           || cfg_index == CFG_IDX_W'(REG_INVERT_MASK)))
                cfg_seen_reg <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result without an outstanding report
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("result without a pending report");

    // at most three reports in flight through the three stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more reports in flight than stages");

    // a rejected frame keeps the wheel state, so positions repeat
    a_reject_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && !cfg_seen_reg |-> m_tdata == last_data_reg)
        else $error("rejected frame moved a position");

    // padding above the four positions stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[127:124] == 4'b0000)
        else $error("padding bits set");

endmodule

bind wheel_encoder_multiturn_unwrap_unit wemu_checker u_wemu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);

/* bench/tb_wheel_encoder_multiturn_unwrap_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_encoder_multiturn_unwrap_unit
// self-checking bench for the four-wheel multi-turn encoder unwrap
//
// encoder reports go in on the s_* stream and positions come back on m_*.
// every accepted report runs through a local copy of the wheel tracking
// (last raw angle, turn count, wrap period, threshold, invert mask), and each
// result is compared field by field with the oldest prediction. a directed
// part covers header matching, threshold edges and register extremes, a
// random part walks the wheels under several settings with idle bursts on
// both sides, and a final part runs steady wraps both ways without idling.
// ----------------------------------------------------------------------------
module tb_wheel_encoder_multiturn_unwrap_unit;
    import wemu_pkg::*;

    localparam int     TURN_W         = TURN_BITS_DEF;
    localparam longint TURN_MAX       = (longint'(1) << (TURN_W - 1)) - 1;
    localparam longint TURN_MIN       = -TURN_MAX - 1;
    localparam longint POS_MAX        = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_MIN        = -POS_MAX - 1;
    localparam logic [RAW_IN_W-1:0] RAW_MASK = RAW_IN_W'((1 << RAW_BITS_DEF) - 1);

    // index past the last register, the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is three deep
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REPORTS  = 220;
    localparam int FINAL_ROUNDS   = 6;

    // one encoder report as it sits on s_tdata, start byte in the low bits
    typedef struct packed {
        logic [WHEELS-1:0][RAW_IN_W-1:0] raw;   // rf at the bottom, lb at the top
        logic [HDR_W-1:0]                cmd;
        logic [HDR_W-1:0]                start;
    } encoder_report_t;

    // one predicted result: tuser flag and the four positions
    typedef struct packed {
        logic                         accepted;
        logic [WHEELS-1:0][POS_W-1:0] pos;
    } wheel_positions_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [79:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [127:0]         m_tdata;
    logic                 m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // tracking state of the local copy
    logic [PERIOD_W-1:0]  model_period;
    logic [THR_W-1:0]     model_threshold;
    logic [WHEELS-1:0]    model_invert;
    logic [RAW_IN_W-1:0]  held_raw [WHEELS];
    longint               turn_cnt [WHEELS];

    wheel_positions_t     expected_positions [$];

    bit                   idle_on;
    int unsigned          fail_count;
    int unsigned          reports_sent;
    int unsigned          results_checked;
    int unsigned          settings_applied;
    int unsigned          quiet_cycles;

    string wheel_field [WHEELS] = '{"pos_right_front", "pos_right_back",
                                    "pos_left_front", "pos_left_back"};

    wheel_encoder_multiturn_unwrap_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // advance the wheel state by one report and return the positions it yields
    function automatic wheel_positions_t unwrap_report(encoder_report_t r);
        wheel_positions_t    res;
        logic                hdr_ok;
        logic [RAW_IN_W-1:0] cur;
        longint              diff;
        longint              pos;
        hdr_ok       = (r.start == HDR_START) && (r.cmd == HDR_CMD);
        res          = '0;
        res.accepted = hdr_ok;
        for (int w = 0; w < WHEELS; w++)
        begin
            // a rejected report reuses the held angle, so the count cannot move
            cur         = hdr_ok ? (r.raw[w] & RAW_MASK) : held_raw[w];
            diff        = longint'(cur) - longint'(held_raw[w]);
            held_raw[w] = cur;
            // jump up means the angle wrapped backwards through zero
            if (diff > longint'(model_threshold))
            begin
                if (turn_cnt[w] > TURN_MIN)
                    turn_cnt[w]--;
            end
            else if (diff < -longint'(model_threshold))
            begin
                if (turn_cnt[w] < TURN_MAX)
                    turn_cnt[w]++;
            end
            pos = longint'(cur) + longint'(model_period) * turn_cnt[w];
            // negate first, then clip to the 31 bit signed range
            if (model_invert[w])
                pos = -pos;
            if (pos > POS_MAX)
                pos = POS_MAX;
            else if (pos < POS_MIN)
                pos = POS_MIN;
            res.pos[w] = pos[POS_W-1:0];
        end
        return res;
    endfunction

    function automatic encoder_report_t frame(logic [HDR_W-1:0] start, logic [HDR_W-1:0] cmd,
                                              logic [RAW_IN_W-1:0] rf, logic [RAW_IN_W-1:0] rb,
                                              logic [RAW_IN_W-1:0] lf, logic [RAW_IN_W-1:0] lb);
        encoder_report_t r;
        r.start  = start;
        r.cmd    = cmd;
        r.raw[0] = rf;
        r.raw[1] = rb;
        r.raw[2] = lf;
        r.raw[3] = lb;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers, all of them start and end just after a falling edge
    // ------------------------------------------------------------------------

    // offer one report, optionally after an idle burst, and hold it until taken
    task automatic send_report(encoder_report_t r);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = r;
        do
            @(posedge clk);
        while (!s_tready);
        // transaction done at this edge
        expected_positions.push_back(unwrap_report(r));
        reports_sent++;
        @(negedge clk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_positions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write enable is left high so that writes can follow back to back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        case (idx)
            REG_WRAP_PERIOD:    model_period    = value[PERIOD_W-1:0];
            REG_JUMP_THRESHOLD: model_threshold = value[THR_W-1:0];
            REG_INVERT_MASK:    model_invert    = value[WHEELS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [PERIOD_W-1:0] period, logic [THR_W-1:0] thr,
                              logic [WHEELS-1:0] mask);
        wait_drained();
        write_reg(REG_WRAP_PERIOD, period);
        write_reg(REG_JUMP_THRESHOLD, thr);
        // junk above the mask bits must be dropped
        write_reg(REG_INVERT_MASK, {12'($urandom_range(0, 4095)), mask});
        cfg_we = 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_reset_state();
        // nothing taken yet, every wheel at raw 0 and turn 0
        send_report(frame(8'h00, 8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
        send_report(frame(HDR_START, HDR_CMD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_header_match();
        // rf and lf jump up through the threshold
        send_report(frame(HDR_START, HDR_CMD, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        // near misses on either byte, and the two bytes swapped
        send_report(frame(HDR_START, 8'h40, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_report(frame(8'hDE, HDR_CMD, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_report(frame(HDR_CMD, HDR_START, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        // rf and lf jump down, rb and lb jump up
        send_report(frame(HDR_START, HDR_CMD, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    endtask

    task automatic test_threshold_edges();
        set_config(WRAP_PERIOD_RST, 16'd1000, 4'b0000);
        send_report(frame(HDR_START, HDR_CMD, 16'd5000, 16'd5000, 16'd5000, 16'd5000));
        // exactly +thr holds, +thr+1 counts down, -thr holds, -thr-1 counts up
        send_report(frame(HDR_START, HDR_CMD, 16'd6000, 16'd6001, 16'd4000, 16'd3999));
        // zero threshold: any movement counts
        set_config(WRAP_PERIOD_RST, 16'd0, 4'b1111);
        send_report(frame(HDR_START, HDR_CMD, 16'd6001, 16'd6001, 16'd4000, 16'd4000));
        send_report(frame(HDR_START, HDR_CMD, 16'd6000, 16'd6001, 16'd3999, 16'd4000));
        // largest threshold: full scale swings never count
        set_config(WRAP_PERIOD_RST, 16'hFFFF, 4'b1010);
        send_report(frame(HDR_START, HDR_CMD, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        send_report(frame(HDR_START, HDR_CMD, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    endtask

    task automatic test_period_extremes();
        // zero period leaves only the raw angle
        set_config(16'd0, JUMP_THRESHOLD_RST, 4'b0101);
        send_report(frame(HDR_START, HDR_CMD, 16'd40000, 16'd1, 16'hFFFF, 16'd12345));
        set_config(16'hFFFF, JUMP_THRESHOLD_RST, 4'b0000);
        send_report(frame(HDR_START, HDR_CMD, 16'd0, 16'd40000, 16'd30000, 16'hFFFF));
        set_config(16'd1, JUMP_THRESHOLD_RST, 4'b1111);
        send_report(frame(HDR_START, HDR_CMD, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        // a write past the last register must change nothing
        wait_drained();
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_we = 1'b0;
        send_report(frame(8'h00, HDR_CMD, 16'd0, 16'd0, 16'd0, 16'd0));
        send_report(frame(HDR_START, HDR_CMD, 16'd100, 16'd50000, 16'd25000, 16'd7));
    endtask

    // mostly well-formed reports whose angles walk, wrap or jump at random
    task automatic test_random_tracking();
        logic [PERIOD_W-1:0] periods [RANDOM_PHASES];
        logic [THR_W-1:0]    thresholds [RANDOM_PHASES];
        logic [WHEELS-1:0]   masks [RANDOM_PHASES];
        logic [RAW_IN_W-1:0] walk [WHEELS];
        encoder_report_t     r;
        periods    = '{WRAP_PERIOD_RST, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(1, 65535))};
        thresholds = '{JUMP_THRESHOLD_RST, 16'd0, 16'hFFFF, 16'($urandom_range(1000, 40000)),
                       16'($urandom)};
        masks      = '{INVERT_MASK_RST, 4'b1111, 4'b0000, 4'($urandom), 4'($urandom)};
        walk       = held_raw;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(periods[p], thresholds[p], masks[p]);
            // one phase runs with no idle bursts at all
            idle_on = (p != 3);
            for (int i = 0; i < PHASE_REPORTS; i++)
            begin
                // now and then hold off until the pipe is empty
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
                case ($urandom_range(0, 19))
                    0:
                    begin
                        r.start = 8'($urandom);
                        r.cmd   = 8'($urandom);
                    end
                    1:
                    begin
                        r.start = HDR_START;
                        r.cmd   = 8'($urandom);
                    end
                    2:
                    begin
                        r.start = 8'($urandom);
                        r.cmd   = HDR_CMD;
                    end
                    default:
                    begin
                        r.start = HDR_START;
                        r.cmd   = HDR_CMD;
                    end
                endcase
                for (int w = 0; w < WHEELS; w++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                            walk[w] = walk[w] + 16'($urandom_range(0, 4000)) - 16'd2000;
                        6, 7:
                            walk[w] = walk[w] + 16'($urandom_range(28000, 37000));
                        default:
                            walk[w] = 16'($urandom);
                    endcase
                    r.raw[w] = walk[w];
                end
                send_report(r);
                walk = held_raw;
            end
        end
    endtask

    // steady wraps in one direction and then the other, back to back
    task automatic test_wrap_run();
        idle_on = 1'b0;
        // large period so that each turn moves the positions far
        set_config(16'hFFFF, 16'd30000, 4'b0101);
        // one jump up and two drops under the threshold: one turn down per round
        repeat (FINAL_ROUNDS)
        begin
            send_report(frame(HDR_START, HDR_CMD, 16'd0, 16'd0, 16'd0, 16'd0));
            send_report(frame(HDR_START, HDR_CMD, 16'd40000, 16'd40000, 16'd40000, 16'd40000));
            send_report(frame(HDR_START, HDR_CMD, 16'd20000, 16'd20000, 16'd20000, 16'd20000));
        end
        // two rises under the threshold and one drop through it: one turn up
        repeat (FINAL_ROUNDS)
        begin
            send_report(frame(HDR_START, HDR_CMD, 16'd20000, 16'd20000, 16'd20000, 16'd20000));
            send_report(frame(HDR_START, HDR_CMD, 16'd40000, 16'd40000, 16'd40000, 16'd40000));
            send_report(frame(HDR_START, HDR_CMD, 16'd0, 16'd0, 16'd0, 16'd0));
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: ready pacing, checking and watchdog
    // ------------------------------------------------------------------------

    // ready runs and, while idling is on, stall bursts, each of random length
    initial
    begin : ready_pacing
        int unsigned run_left;
        m_tready = 1'b0;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (run_left != 0)
                run_left--;
            else if (m_tready && idle_on)
            begin
                m_tready = 1'b0;
                run_left = $urandom_range(0, 7);
            end
            else
            begin
                m_tready = 1'b1;
                run_left = $urandom_range(0, 15);
            end
        end
    end

    // every result transaction is matched against the oldest prediction
    always @(posedge clk)
    begin : position_check
        wheel_positions_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (expected_positions.size() == 0)
            begin
                $error("result with no report outstanding: tuser %b tdata %h", m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (m_tuser !== want.accepted)
                begin
                    $error("frame_accepted expected %b actual %b", want.accepted, m_tuser);
                    fail_count++;
                end
                for (int w = 0; w < WHEELS; w++)
                begin
                    if (m_tdata[w*POS_W +: POS_W] !== want.pos[w])
                    begin
                        $error("%s expected %0d actual %0d", wheel_field[w],
                               $signed(want.pos[w]), $signed(m_tdata[w*POS_W +: POS_W]));
                        fail_count++;
                    end
                end
                if (m_tdata[127:WHEELS*POS_W] !== '0)
                begin
                    $error("padding expected 0 actual %h", m_tdata[127:WHEELS*POS_W]);
                    fail_count++;
                end
            end
        end
    end

    // cycles in a row with no transaction on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_positions.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_we           = 1'b0;
        cfg_index        = REG_WRAP_PERIOD;
        cfg_data         = '0;
        idle_on          = 1'b1;
        fail_count       = 0;
        reports_sent     = 0;
        results_checked  = 0;
        settings_applied = 0;
        // local copy starts from the reset defaults
        model_period     = WRAP_PERIOD_RST;
        model_threshold  = JUMP_THRESHOLD_RST;
        model_invert     = INVERT_MASK_RST;
        foreach (held_raw[w])
        begin
            held_raw[w] = '0;
            turn_cnt[w] = 0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_header_match();
        test_threshold_edges();
        test_period_extremes();
        test_random_tracking();
        // last part of the run, no idling from here on
        test_wrap_run();
        wait_drained();

        $display("covered %0d reports and %0d results under %0d register settings,",
                 reports_sent, results_checked, settings_applied);
        $display("header near misses, threshold edges, period extremes and steady wraps");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
